/* hw/rtl/tlbp_pkg.sv */
// Shared types and constants for the two-level local branch predictor.
package tlbp_pkg;

	// Address and register widths
	localparam int unsigned PC_W      = 32;
	localparam int unsigned PC_IDX_LO = 2;
	localparam int unsigned PC_IDX_W  = PC_W - PC_IDX_LO;
	localparam int unsigned CFG_W     = 4;
	localparam int unsigned CTR_W     = 8;

	// Legal range and reset value of the counter width register
	localparam logic [CFG_W-1:0] CTR_BITS_MIN   = 4'd2;
	localparam logic [CFG_W-1:0] CTR_BITS_MAX   = 4'd8;
	localparam logic [CFG_W-1:0] CTR_BITS_RESET = 4'd2;

	// Input beat: one resolved branch
	typedef struct packed {
		logic [PC_W-1:0] pc;
		logic            taken;
	} in_t;

	// Output beat: prediction and its outcome
	typedef struct packed {
		logic predicted_taken;
		logic correct;
	} out_t;

	// Per-stage control handed to the table stages
	typedef struct packed {
		logic adv;       // pipeline moves this cycle
		logic wr_valid;  // the stage that updates the table holds a branch
	} stage_ctl_t;

endpackage

/* hw/rtl/tlbp_hist.sv */
// Local history table stage: history read, forwarding and shift update.
module tlbp_hist #(
	parameter int unsigned HISTORY_ENTRIES = 128,
	parameter int unsigned PATTERN_ENTRIES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tlbp_pkg::stage_ctl_t                 ctl,
	input  logic [$clog2(HISTORY_ENTRIES)-1:0]   hidx_s1,
	input  logic                                 taken_s1,
	output logic [$clog2(PATTERN_ENTRIES)-1:0]   hist_s2,
	output logic                                 taken_s2
);
	import tlbp_pkg::*;

	localparam int unsigned HW = $clog2(HISTORY_ENTRIES);
	localparam int unsigned PW = $clog2(PATTERN_ENTRIES);
	localparam logic [PW:0] PE_W = (PW+1)'(PATTERN_ENTRIES);

	logic [PW-1:0]              mem_q [HISTORY_ENTRIES];
	logic [HISTORY_ENTRIES-1:0] valid_q;

	logic [HW-1:0] hidx_s2;
	logic [PW-1:0] rd_s2;
	logic          rdv_s2;
	logic          byp_s2;
	logic [PW-1:0] byp_val_s2;

	logic [PW:0]   shifted;
	logic [PW:0]   wrapped;
	logic [PW-1:0] hist_next;

	// Resolve current history: forwarded write wins, unwritten entries read as zero
	always_comb begin
		if (byp_s2) begin
			hist_s2 = byp_val_s2;
		end else if (rdv_s2) begin
			hist_s2 = rd_s2;
		end else begin
			hist_s2 = '0;
		end
	end

	// Shift outcome in, wrap to the pattern table size
	always_comb begin
		shifted = {hist_s2, taken_s2};
		wrapped = shifted - PE_W;
		if (shifted >= PE_W) begin
			hist_next = wrapped[PW-1:0];
		end else begin
			hist_next = shifted[PW-1:0];
		end
	end

	// Valid bits and forward flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			byp_s2  <= 1'b0;
		end else if (ctl.adv) begin
			if (ctl.wr_valid) begin
				valid_q[hidx_s2] <= 1'b1;
			end
			byp_s2 <= ctl.wr_valid && (hidx_s2 == hidx_s1);
		end
	end

	// History memory: registered read, write from the stage below
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rd_s2      <= mem_q[hidx_s1];
			rdv_s2     <= valid_q[hidx_s1];
			hidx_s2    <= hidx_s1;
			taken_s2   <= taken_s1;
			byp_val_s2 <= hist_next;
			if (ctl.wr_valid) begin
				mem_q[hidx_s2] <= hist_next;
			end
		end
	end

endmodule

/* hw/rtl/tlbp_ctr.sv */
// Pattern counter table stage: counter read, prediction and saturating update.
module tlbp_ctr #(
	parameter int unsigned PATTERN_ENTRIES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlbp_pkg::stage_ctl_t                ctl,
	input  logic [$clog2(PATTERN_ENTRIES)-1:0]  hist_s2,
	input  logic                                taken_s2,
	input  logic [tlbp_pkg::CFG_W-1:0]          ctr_bits,
	output logic                                clr_busy,
	output tlbp_pkg::out_t                      res_s3
);
	import tlbp_pkg::*;

	localparam int unsigned PW = $clog2(PATTERN_ENTRIES);
	localparam logic [PW-1:0] LAST_ADDR = PW'(PATTERN_ENTRIES - 1);

	logic [CTR_W-1:0] mem_q [PATTERN_ENTRIES];

	logic          clr_busy_q;
	logic [PW-1:0] clr_addr_q;

	logic [PW-1:0]    hist_s3;
	logic             taken_s3;
	logic [CTR_W-1:0] rd_s3;
	logic             byp_s3;
	logic [CTR_W-1:0] byp_val_s3;

	logic [CTR_W-1:0] ctr_raw;
	logic [CTR_W-1:0] ctr;
	logic [CTR_W-1:0] maxv;
	logic [CTR_W-1:0] half;
	logic [CTR_W-1:0] ctr_next;
	logic             pred;

	assign clr_busy = clr_busy_q;

	// Counter bounds for the configured width
	assign maxv = CTR_W'((9'd1 << ctr_bits) - 9'd1);
	assign half = CTR_W'(9'd1 << (ctr_bits - 4'd1));

	// Prediction from clamped counter, then step toward outcome
	always_comb begin
		ctr_raw = byp_s3 ? byp_val_s3 : rd_s3;
		ctr     = (ctr_raw > maxv) ? maxv : ctr_raw;
		pred    = (ctr >= half);
		ctr_next = ctr;
		if (taken_s3) begin
			if (ctr < maxv) begin
				ctr_next = ctr + 1'b1;
			end
		end else begin
			if (ctr != '0) begin
				ctr_next = ctr - 1'b1;
			end
		end
		res_s3.predicted_taken = pred;
		res_s3.correct         = (pred == taken_s3);
	end

	// Clear sweep after reset and forward flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			byp_s3     <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (ctl.adv) begin
				byp_s3 <= ctl.wr_valid && (hist_s3 == hist_s2);
			end
		end
	end

	// Counter memory: registered read, single write port shared with the sweep
	always_ff @(posedge clk) begin
		priority if (clr_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (ctl.adv && ctl.wr_valid) begin
			mem_q[hist_s3] <= ctr_next;
		end
		if (ctl.adv) begin
			rd_s3      <= mem_q[hist_s2];
			hist_s3    <= hist_s2;
			taken_s3   <= taken_s2;
			byp_val_s3 <= ctr_next;
		end
	end

endmodule

/* hw/rtl/two_level_local_branch_predictor_core.sv */
// Top level of the two-level local branch predictor.
// Takes one resolved branch (pc, taken) per cycle unless in_stall is high and returns one
// beat per branch: the prediction read from the pattern counter before the update and
// whether it matched. Bits pc[31:2] modulo HISTORY_ENTRIES pick a local history; that
// history picks a saturating counter whose width is set by the cfg register (2..8,
// clamped). The pipeline is four registers deep (index, history read, counter read,
// output), and a new branch can enter every cycle while in_stall is low; back-to-back
// branches to the same entries are forwarded. A stalled output holds the whole
// pipeline. After reset the counter table is swept to zero, one entry a cycle, so
// in_stall stays high until all PATTERN_ENTRIES entries (1024 by default) are cleared.
module two_level_local_branch_predictor_core #(
	parameter int unsigned HISTORY_ENTRIES = 128,
	parameter int unsigned PATTERN_ENTRIES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  tlbp_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output tlbp_pkg::out_t               out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tlbp_pkg::CFG_W-1:0]   cfg_data
);
	import tlbp_pkg::*;

	localparam int unsigned HW = $clog2(HISTORY_ENTRIES);
	localparam int unsigned PW = $clog2(PATTERN_ENTRIES);
	localparam int unsigned SH = PC_IDX_W + HW;
	// Reciprocal of HISTORY_ENTRIES, exact floor for any 30-bit word index
	localparam logic [63:0] RECIP_SCALE = 64'd1 << SH;
	localparam logic [63:0] RECIP64 = (RECIP_SCALE + HISTORY_ENTRIES - 1) / HISTORY_ENTRIES;
	localparam logic [31:0] RECIP = RECIP64[31:0];
	localparam int unsigned PROD_W = PC_IDX_W + 32;
	localparam logic [HW:0] HE_FULL = (HW+1)'(HISTORY_ENTRIES);
	localparam logic [HW-1:0] HE_LO = HE_FULL[HW-1:0];

	logic en;
	logic accept;
	logic clr_busy;

	logic [CFG_W-1:0] ctr_bits_q;

	logic [PROD_W-1:0] recip_prod;
	logic [PROD_W-1:0] quot_full;

	logic          v_s1, v_s2, v_s3;
	logic [HW-1:0] xlo_s1;
	logic [HW-1:0] qlo_s1;
	logic          taken_s1;
	logic [HW-1:0] qhe_s1;
	logic [HW-1:0] hidx_s1;

	logic [PW-1:0] hist_s2;
	logic          taken_s2;
	out_t          res_s3;

	logic out_valid_q;
	out_t out_q;

	stage_ctl_t ctl_hist;
	stage_ctl_t ctl_ctr;

	// Handshake: whole pipeline moves unless a held result is stalled
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en || clr_busy;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Config register, stored already clamped to its legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_bits_q <= CTR_BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			priority if (cfg_data < CTR_BITS_MIN) begin
				ctr_bits_q <= CTR_BITS_MIN;
			end else if (cfg_data > CTR_BITS_MAX) begin
				ctr_bits_q <= CTR_BITS_MAX;
			end else begin
				ctr_bits_q <= cfg_data;
			end
		end
	end

	// Quotient of the word index by HISTORY_ENTRIES
	assign recip_prod = PROD_W'(in_data.pc[PC_W-1:PC_IDX_LO]) * PROD_W'(RECIP);
	assign quot_full  = recip_prod >> SH;

	// Remainder needs only the low bits of index and quotient
	assign qhe_s1  = qlo_s1 * HE_LO;
	assign hidx_s1 = xlo_s1 - qhe_s1;

	// Stage valids and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			xlo_s1   <= in_data.pc[PC_IDX_LO +: HW];
			qlo_s1   <= quot_full[HW-1:0];
			taken_s1 <= in_data.taken;
			out_q    <= res_s3;
		end
	end

	assign ctl_hist = '{adv: en, wr_valid: v_s2};
	assign ctl_ctr  = '{adv: en, wr_valid: v_s3};

	tlbp_hist #(
		.HISTORY_ENTRIES(HISTORY_ENTRIES),
		.PATTERN_ENTRIES(PATTERN_ENTRIES)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_hist),
		.hidx_s1  (hidx_s1),
		.taken_s1 (taken_s1),
		.hist_s2  (hist_s2),
		.taken_s2 (taken_s2)
	);

	tlbp_ctr #(
		.PATTERN_ENTRIES(PATTERN_ENTRIES)
	) u_ctr (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_ctr),
		.hist_s2  (hist_s2),
		.taken_s2 (taken_s2),
		.ctr_bits (ctr_bits_q),
		.clr_busy (clr_busy),
		.res_s3   (res_s3)
	);

endmodule

/* dv/two_level_local_branch_predictor_core_tb.sv */
// Self-checking testbench for the two-level local branch predictor core.
module two_level_local_branch_predictor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlbp_pkg::*;

	localparam int unsigned HIST_N      = 128;
	localparam int unsigned PAT_N       = 1024;
	localparam int unsigned HIST_W      = $clog2(PAT_N);
	localparam int unsigned IDLE_LIMIT  = 5000;
	localparam int unsigned SETTLE_CYC  = 16;
	localparam int unsigned N_SEGMENTS  = 12;

	// One directed branch, with its result written out where it is obvious
	typedef struct {
		logic [PC_W-1:0] pc;
		logic            taken;
		bit              typed;
		out_t            want;
	} branch_row_t;

	// A predicted outcome waiting for its beat
	typedef struct {
		logic [PC_W-1:0] pc;
		out_t            res;
	} pending_pred_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// Shadow copy of the predictor state
	logic [HIST_W-1:0] local_hist [HIST_N];
	logic [CTR_W-1:0]  pattern_ctr [PAT_N];
	logic [CFG_W-1:0]  ctr_width;

	pending_pred_t pending_preds [$];
	int unsigned   mismatch_count = 0;
	int unsigned   result_count   = 0;
	int unsigned   idle_cycles    = 0;
	int unsigned   send_idle_pct  = 0;
	int unsigned   stall_pct      = 0;

	// Per-segment pool of hot branches
	logic [6:0]    hot_idx [5];
	logic          alt_taken;

	branch_row_t   dir_rows [16];
	logic [CFG_W-1:0] seg_width [N_SEGMENTS];
	int unsigned   seg_items [N_SEGMENTS];

	two_level_local_branch_predictor_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(string msg);
		$display("ERROR: %s", msg);
		mismatch_count++;
	endtask

	// Prediction from the counter before the update, then counter and history update
	function automatic out_t predict_branch(in_t br);
		logic [3:0]        w;
		logic [8:0]        maxv;
		logic [8:0]        half;
		int unsigned       hidx;
		logic [HIST_W-1:0] hist;
		logic [8:0]        ctr;
		out_t              r;
		if (ctr_width < CTR_BITS_MIN) begin
			w = CTR_BITS_MIN;
		end else if (ctr_width > CTR_BITS_MAX) begin
			w = CTR_BITS_MAX;
		end else begin
			w = ctr_width;
		end
		maxv = (9'd1 << w) - 9'd1;
		half = 9'd1 << (w - 4'd1);
		hidx = (br.pc >> PC_IDX_LO) % HIST_N;
		hist = local_hist[hidx];
		ctr  = {1'b0, pattern_ctr[hist]};
		// counter left over from a wider setting is clamped first
		if (ctr > maxv) begin
			ctr = maxv;
		end
		r.predicted_taken = (ctr >= half);
		r.correct         = (r.predicted_taken == br.taken);
		if (br.taken) begin
			if (ctr < maxv) begin
				ctr = ctr + 9'd1;
			end
		end else if (ctr != 9'd0) begin
			ctr = ctr - 9'd1;
		end
		pattern_ctr[hist] = ctr[CTR_W-1:0];
		local_hist[hidx]  = {hist[HIST_W-2:0], br.taken};
		return r;
	endfunction

	// Drive one branch beat; record its expected result on acceptance
	task automatic send_branch(logic [PC_W-1:0] pc, logic taken, bit typed, out_t want);
		pending_pred_t p;
		out_t          r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid      = 1'b1;
		in_data.pc    = pc;
		in_data.taken = taken;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		r     = predict_branch(in_data);
		p.pc  = pc;
		p.res = typed ? want : r;
		pending_preds.push_back(p);
	endtask

	// Hold off input until every pending result has come back, then let the pipe settle
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_preds.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_ctr_width(logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		ctr_width = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly hot branches with fixed, alternating or biased behavior, the rest arbitrary
	task automatic run_random_branches(int unsigned n);
		logic [PC_W-1:0] pc;
		logic            taken;
		int unsigned     k;
		out_t            none;
		none = '0;
		for (int unsigned i = 0; i < n; i++) begin
			pc = $urandom();
			if ($urandom_range(99) < 80) begin
				k = ($urandom_range(99) < 50) ? $urandom_range(1) : $urandom_range(4, 2);
				pc[8:2] = hot_idx[k];
				case (k)
					0, 1: taken = 1'b1;
					2: taken = 1'b0;
					3: begin
						taken     = alt_taken;
						alt_taken = ~alt_taken;
					end
					default: taken = ($urandom_range(99) < 85);
				endcase
			end else begin
				taken = 1'($urandom_range(1));
			end
			send_branch(pc, taken, 1'b0, none);
		end
	endtask

	// Receiver stall
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// Result checker
	always @(posedge clk) begin
		pending_pred_t exp_p;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_preds.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing pending (pred %0b correct %0b)",
					result_count, out_data.predicted_taken, out_data.correct));
			end else begin
				exp_p = pending_preds.pop_front();
				if (out_data.predicted_taken !== exp_p.res.predicted_taken) begin
					report_mismatch($sformatf("result %0d pc %h: predicted_taken %b, want %b",
						result_count, exp_p.pc, out_data.predicted_taken,
						exp_p.res.predicted_taken));
				end
				if (out_data.correct !== exp_p.res.correct) begin
					report_mismatch($sformatf("result %0d pc %h: correct %b, want %b",
						result_count, exp_p.pc, out_data.correct, exp_p.res.correct));
				end
			end
			result_count++;
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		alt_taken = 1'b0;
		ctr_width = CTR_BITS_RESET;
		foreach (local_hist[i]) local_hist[i] = '0;
		foreach (pattern_ctr[i]) pattern_ctr[i] = '0;

		// Directed branches at the reset width: address extremes, aliasing, saturation
		dir_rows = '{
			'{32'h0000_0000, 1'b1, 1'b1, '{1'b0, 1'b0}},
			'{32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 1'b1}},
			'{32'h0000_0004, 1'b1, 1'b1, '{1'b0, 1'b0}},
			'{32'h0000_0000, 1'b1, 1'b0, '{1'b0, 1'b0}},
			'{32'h0000_0000, 1'b1, 1'b0, '{1'b0, 1'b0}},
			'{32'h0000_0000, 1'b1, 1'b0, '{1'b0, 1'b0}},
			'{32'h0000_0000, 1'b1, 1'b0, '{1'b0, 1'b0}},
			'{32'h0000_01FC, 1'b1, 1'b0, '{1'b0, 1'b0}},
			'{32'h0000_01FC, 1'b1, 1'b0, '{1'b0, 1'b0}},
			'{32'h0000_01FC, 1'b1, 1'b0, '{1'b0, 1'b0}},
			'{32'hFFFF_FE00, 1'b0, 1'b0, '{1'b0, 1'b0}},
			'{32'hAAAA_AAAA, 1'b1, 1'b0, '{1'b0, 1'b0}},
			'{32'h5555_5555, 1'b0, 1'b0, '{1'b0, 1'b0}},
			'{32'h0000_0000, 1'b0, 1'b0, '{1'b0, 1'b0}},
			'{32'h0000_0000, 1'b0, 1'b0, '{1'b0, 1'b0}},
			'{32'h8000_0003, 1'b1, 1'b0, '{1'b0, 1'b0}}
		};

		// Width per segment: out-of-range values, both extremes, and a shrink right after 8
		seg_width = '{4'd15, 4'd2, 4'd8, 4'd0, 4'd5, 4'd1, 4'd9, 4'd3, 4'd6, 4'd4, 4'd7,
			4'd8};
		seg_items = '{600, 120, 120, 120, 120, 120, 120, 120, 120, 120, 120, 120};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 6;
		stall_pct     = 65;
		foreach (dir_rows[i]) begin
			send_branch(dir_rows[i].pc, dir_rows[i].taken, dir_rows[i].typed, dir_rows[i].want);
		end
		drain_results();

		for (int unsigned s = 0; s < N_SEGMENTS; s++) begin
			// receiver-heavy stalls, then sender-heavy gaps, then full rate
			if (s < 4) begin
				send_idle_pct = 6;
				stall_pct     = 65;
			end else if (s < 8) begin
				send_idle_pct = 65;
				stall_pct     = 6;
			end else begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			write_ctr_width(seg_width[s]);
			foreach (hot_idx[k]) hot_idx[k] = 7'($urandom_range(HIST_N - 1));
			run_random_branches(seg_items[s]);
			drain_results();
		end

		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatch_count == 0 && pending_preds.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
